// File: sv/mtd_pkg.sv
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared constants, command codes and types of the hash tree difference map.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int LEAVES_DEF     = 256;
  localparam int HASH_WORDS_DEF = 4;
  localparam int WORD_BITS      = 64;
  localparam int MAP_WORDS      = 4;
  localparam int LVW            = 4;

  localparam logic [LVW-1:0] LEVELS_RESET = 4'd9;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  // tag that travels with each hash read
  typedef struct packed {
    logic last_word;
    logic odd;
    logic last_node;
    logic last_level;
    logic is_root;
    logic desc;
  } rd_tag_t;

endpackage

// File: sv/mtd_in_if.sv
// ----------------------------------------------------------------------------
// mtd_in_if
// Command channel: load hash words or start a difference run.
// ----------------------------------------------------------------------------
interface mtd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [8:0]  node_index;
  logic [1:0]  word_index;
  logic [63:0] hash_word;

  modport source (output valid, cmd, node_index, word_index, hash_word, input ready);
  modport sink   (input valid, cmd, node_index, word_index, hash_word, output ready);
endinterface

// File: sv/mtd_out_if.sv
// ----------------------------------------------------------------------------
// mtd_out_if
// Result channel: difference bitmap words.
// ----------------------------------------------------------------------------
interface mtd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] map_word;
  logic [1:0]  map_index;
  logic        subtree_equal;
  logic        last;

  modport source (output valid, map_word, map_index, subtree_equal, last, input ready);
  modport sink   (input valid, map_word, map_index, subtree_equal, last, output ready);
endinterface

// File: sv/mtd_ram.sv
// ----------------------------------------------------------------------------
// mtd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mtd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2044
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/merkle_tree_diff_map_top.sv
// Load words take one cycle each and give no result; the next word is taken at once.
// A run on a subtree of depth D reads up to (2^(D+1)-1)*HASH_WORDS words from each
// tree memory, one per cycle at a shared read address; read data and tag are
// registered, S_OUT is entered, and the 1 to 4 bitmap words are registered one per
// cycle while not stalled; no command is taken from run start until the last one is.
// Reset clears control and sets tree_levels to 9; hash memories keep their contents.
// ----------------------------------------------------------------------------
// merkle_tree_diff_map_top
// Holds two hash trees and emits the bitmap of differing leaves of a subtree.
// ----------------------------------------------------------------------------
module merkle_tree_diff_map_top #(
  parameter int LEAVES     = mtd_pkg::LEAVES_DEF,
  parameter int HASH_WORDS = mtd_pkg::HASH_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [mtd_pkg::LVW-1:0] cfg_wdata,
  mtd_in_if.sink                  in_ch,
  mtd_out_if.source               out_ch
);
  import mtd_pkg::*;

  localparam int NODE_CAP  = 2 * LEAVES - 1;
  localparam int STORE_CAP = NODE_CAP * HASH_WORDS;
  localparam int AW        = STORE_CAP > 1 ? $clog2(STORE_CAP) : 1;
  localparam int LVL_CAP   = $clog2(LEAVES + 1);
  localparam int NW        = LVL_CAP;
  localparam int WW        = HASH_WORDS > 1 ? $clog2(HASH_WORDS) : 1;
  localparam int MAPB      = MAP_WORDS * WORD_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]     state;
  logic [LVW-1:0] tree_levels;
  logic [LVW-1:0] lv_eff;
  logic [15:0]    nodes;
  logic [9:0]     root_p1;
  logic [LVW-1:0] root_dep;
  logic [LVW-1:0] depth_run;
  logic [LVW-1:0] depth;
  logic           in_acc;
  logic           ld_ok;
  logic           run_ok;
  logic [19:0]    wa_full;
  logic [AW-1:0]  waddr;
  logic           we_a;
  logic           we_b;

  // issue side
  logic           iss_on;
  logic [LVW-1:0] iss_d;
  logic [WW-1:0]  iss_w;
  logic [NW-1:0]  iss_n;
  logic [NW-1:0]  iss_first;
  logic [NW-1:0]  iss_last;
  logic           iss_desc;
  logic [NW-1:0]  f2;
  logic [NW-1:0]  l2;
  logic [19:0]    ra_full;
  logic [AW-1:0]  raddr;
  rd_tag_t        tag;
  logic           iss_go;

  // result side
  logic            rd_vld;
  rd_tag_t         rd_tag;
  logic [63:0]     qa;
  logic [63:0]     qb;
  logic            acc;
  logic            differs;
  logic            parent;
  logic            b;
  logic [LEAVES-1:0] curv;
  logic [LEAVES-1:0] cur_next;
  logic [LEAVES-1:0] prev;
  logic            eq;

  // output side
  logic [1:0]     kk;
  logic [1:0]     nw_m1;
  logic [MAPB-1:0] pad;
  logic [63:0]    mword;
  logic           out_valid;
  logic [63:0]    map_word;
  logic [1:0]     map_index;
  logic           subtree_equal;
  logic           last;
  logic           out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_levels <= LEVELS_RESET;
    end else if (cfg_we) begin
      tree_levels <= cfg_wdata;
    end
  end

  // clamp levels and find the run root's depth
  always_comb begin
    if (tree_levels == '0) begin
      lv_eff = LVW'(1);
    end else if (tree_levels > LVW'(LVL_CAP)) begin
      lv_eff = LVW'(LVL_CAP);
    end else begin
      lv_eff = tree_levels;
    end
    nodes    = (16'd1 << lv_eff) - 16'd1;
    root_p1  = {1'b0, in_ch.node_index} + 10'd1;
    root_dep = '0;
    for (int i = 0; i < 10; i++) begin
      if (root_p1[i]) begin
        root_dep = LVW'(i);
      end
    end
    depth_run = lv_eff - LVW'(1) - root_dep;
  end

  // load path
  assign ld_ok   = (16'(in_ch.node_index) < 16'(NODE_CAP)) &&
                   (16'(in_ch.word_index) < 16'(HASH_WORDS));
  assign run_ok  = (16'(in_ch.node_index) < nodes);
  assign wa_full = 20'(in_ch.node_index) * 20'(HASH_WORDS) + 20'(in_ch.word_index);
  assign waddr   = AW'(wa_full);
  assign we_a    = in_acc && (in_ch.cmd == CMD_LOAD_A) && ld_ok;
  assign we_b    = in_acc && (in_ch.cmd == CMD_LOAD_B) && ld_ok;

  // issue address and tag
  assign ra_full        = 20'(iss_n) * 20'(HASH_WORDS) + 20'(iss_w);
  assign raddr          = AW'(ra_full);
  assign tag.last_word  = (iss_w == WW'(HASH_WORDS - 1));
  assign tag.odd        = iss_n[0] ^ iss_first[0];
  assign tag.last_node  = iss_desc ? (iss_n == iss_first) : (iss_n == iss_last);
  assign tag.last_level = (iss_d == depth);
  assign tag.is_root    = (iss_d == '0);
  assign tag.desc       = iss_desc;
  assign iss_go         = (state == S_RUN) && iss_on;
  assign f2             = (iss_first << 1) | NW'(1);
  assign l2             = (iss_last << 1) + NW'(2);

  mtd_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_CAP)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_ch.hash_word),
    .raddr (raddr),
    .rdata (qa)
  );

  mtd_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_CAP)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_ch.hash_word),
    .raddr (raddr),
    .rdata (qb)
  );

  // compare and mark
  always_comb begin
    differs = acc | (qa != qb);
    parent  = rd_tag.desc ? prev[LEAVES-1] : prev[0];
    b       = parent & differs;
    if (rd_tag.desc) begin
      cur_next = (curv << 1) | LEAVES'(b);
    end else begin
      cur_next = (curv >> 1) | (LEAVES'(b) << (LEAVES - 1));
    end
  end

  // final bitmap, padded to the output span
  genvar gi;
  generate
    for (gi = 0; gi < MAPB; gi++) begin : g_pad
      if (gi < LEAVES) begin : g_in
        assign pad[gi] = prev[gi];
      end else begin : g_out
        assign pad[gi] = 1'b0;
      end
    end
  endgenerate

  // select the word and drop bits past the subtree's leaf count
  always_comb begin
    mword = pad[kk * WORD_BITS +: WORD_BITS];
    for (int i = 0; i < WORD_BITS; i++) begin
      if (depth < LVW'(8)) begin
        if ((16'({kk, 6'(i)}) >> depth) != 16'd0) begin
          mword[i] = 1'b0;
        end
      end
    end
    if (depth <= LVW'(6)) begin
      nw_m1 = 2'd0;
    end else if (depth == LVW'(7)) begin
      nw_m1 = 2'd1;
    end else begin
      nw_m1 = 2'd3;
    end
  end

  assign out_free = !out_valid || out_ch.ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss_on    <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= iss_go;
      if (out_valid && out_ch.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_ch.cmd == CMD_RUN) && run_ok) begin
            state  <= S_RUN;
            iss_on <= 1'b1;
          end
        end
        S_RUN: begin
          if (iss_go && tag.last_word && tag.last_node && tag.last_level) begin
            iss_on <= 1'b0;
          end
          if (rd_vld && rd_tag.last_word) begin
            if ((rd_tag.is_root && !differs) || (rd_tag.last_node && rd_tag.last_level)) begin
              state  <= S_OUT;
              iss_on <= 1'b0;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (eq || kk == nw_m1) begin
              state <= S_IDLE;
            end
          end else if (out_valid && out_ch.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // run datapath
  always_ff @(posedge clk) begin
    rd_tag <= tag;
    if (state == S_IDLE && in_acc) begin
      depth     <= depth_run;
      iss_d     <= '0;
      iss_w     <= '0;
      iss_n     <= NW'(in_ch.node_index);
      iss_first <= NW'(in_ch.node_index);
      iss_last  <= NW'(in_ch.node_index);
      iss_desc  <= ~depth_run[0];
      prev      <= '1;
      acc       <= 1'b0;
      eq        <= 1'b0;
      kk        <= '0;
    end
    // advance the read walk
    if (iss_go) begin
      if (tag.last_word) begin
        iss_w <= '0;
        if (tag.last_node) begin
          iss_d     <= iss_d + LVW'(1);
          iss_first <= f2;
          iss_last  <= l2;
          iss_desc  <= ~iss_desc;
          iss_n     <= iss_desc ? f2 : l2;
        end else begin
          iss_n <= iss_desc ? iss_n - NW'(1) : iss_n + NW'(1);
        end
      end else begin
        iss_w <= iss_w + WW'(1);
      end
    end
    // fold word compares into node marks
    if (state == S_RUN && rd_vld) begin
      if (!rd_tag.last_word) begin
        acc <= differs;
      end else begin
        acc  <= 1'b0;
        curv <= cur_next;
        if (rd_tag.last_node) begin
          prev <= cur_next;
        end else if (rd_tag.desc && !rd_tag.odd) begin
          prev <= prev << 1;
        end else if (!rd_tag.desc && rd_tag.odd) begin
          prev <= prev >> 1;
        end
        if (rd_tag.is_root && !differs) begin
          eq <= 1'b1;
        end
      end
    end
    // load the output register
    if (state == S_OUT && out_free) begin
      map_word      <= eq ? 64'd0 : mword;
      map_index     <= eq ? 2'd0 : kk;
      subtree_equal <= eq;
      last          <= eq || (kk == nw_m1);
      kk            <= kk + 2'd1;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.map_word      = map_word;
  assign out_ch.map_index     = map_index;
  assign out_ch.subtree_equal = subtree_equal;
  assign out_ch.last          = last;

endmodule

// File: sv/mtd_chk.sv
// ----------------------------------------------------------------------------
// mtd_chk
// Port-level checks of the difference map block, bound to the top level.
// ----------------------------------------------------------------------------
module mtd_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] map_word,
  input logic [1:0]  map_index,
  input logic        subtree_equal,
  input logic        last
);
  import mtd_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(map_word) && $stable(map_index))
    else $error("stalled output word changed");

  // block commands while a run still has words to send
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("command taken in the middle of a run");

  // equal roots give a single empty word
  a_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && subtree_equal |-> map_word == 64'd0 && map_index == 2'd0 && last)
    else $error("bad equal-root word");

  // loads never stall the next word
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_cmd == CMD_LOAD_A || in_cmd == CMD_LOAD_B) |=> in_ready)
    else $error("load blocked the command channel");

endmodule

bind merkle_tree_diff_map_top mtd_chk u_mtd_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_cmd        (in_ch.cmd),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .map_word      (out_ch.map_word),
  .map_index     (out_ch.map_index),
  .subtree_equal (out_ch.subtree_equal),
  .last          (out_ch.last)
);

// File: tb/mtd_diff_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtd_diff_checker
// Watches the command and bitmap channels, keeps its own copy of both hash
// trees and the level count, predicts the bitmap words of each run and
// compares every accepted bitmap word with the oldest prediction.
// ----------------------------------------------------------------------------
module mtd_diff_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [mtd_pkg::LVW-1:0] cfg_wdata,
  mtd_in_if.sink                  in_mon,
  mtd_out_if.sink                 out_mon,
  output int                      fail_count,
  output int                      words_pending
);
  import mtd_pkg::*;

  localparam int NODE_CAP  = 2 * LEAVES_DEF - 1;
  localparam int MAX_LEVEL = 9;

  typedef struct packed {
    logic [63:0] map_word;
    logic [1:0]  map_index;
    logic        subtree_equal;
    logic        last;
  } map_word_t;

  logic [63:0] tree_a [NODE_CAP*HASH_WORDS_DEF];
  logic [63:0] tree_b [NODE_CAP*HASH_WORDS_DEF];
  logic [LVW-1:0] levels_q;
  map_word_t bitmap_q[$];

  assign words_pending = bitmap_q.size();

  function automatic logic node_differs(int n);
    logic d;
    d = 1'b0;
    if (n < NODE_CAP)
      for (int w = 0; w < HASH_WORDS_DEF; w++)
        if (tree_a[n*HASH_WORDS_DEF+w] !== tree_b[n*HASH_WORDS_DEF+w]) d = 1'b1;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Walk the subtree level by level and queue the bitmap words
  task automatic predict_bitmap(input int root);
    int lv, dep, base, nw, first;
    logic alive [256];
    map_word_t mw;
    lv = levels_q;
    if (lv < 1) lv = 1;
    if (lv > MAX_LEVEL) lv = MAX_LEVEL;
    if (root >= (1 << lv) - 1) return;
    if (!node_differs(root)) begin
      mw = '{map_word: '0, map_index: '0, subtree_equal: 1'b1, last: 1'b1};
      bitmap_q.push_back(mw);
      return;
    end
    dep = lv - 1 - ($clog2(root + 2) - 1);
    base = 1 << dep;
    alive[0] = 1'b1;
    for (int d = 1; d <= dep; d++) begin
      first = ((root + 1) << d) - 1;
      for (int o = (1 << d) - 1; o >= 0; o--)
        alive[o] = alive[o >> 1] && node_differs(first + o);
    end
    nw = (base + 63) / 64;
    if (nw > MAP_WORDS) nw = MAP_WORDS;
    for (int k = 0; k < nw; k++) begin
      mw = '0;
      for (int i = 0; i < 64; i++)
        if (k*64 + i < base && alive[k*64 + i]) mw.map_word[i] = 1'b1;
      mw.map_index = k[1:0];
      mw.last = (k == nw - 1);
      bitmap_q.push_back(mw);
    end
  endtask

  initial fail_count = 0;

  // Track configuration and loads, predict runs, check bitmap words
  always @(posedge clk) begin
    map_word_t want;
    if (rst) begin
      levels_q = LEVELS_RESET;
    end else begin
      if (cfg_we) levels_q = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        if ((in_mon.cmd == CMD_LOAD_A || in_mon.cmd == CMD_LOAD_B)
            && in_mon.node_index < NODE_CAP) begin
          if (in_mon.cmd == CMD_LOAD_A)
            tree_a[in_mon.node_index*HASH_WORDS_DEF + in_mon.word_index] = in_mon.hash_word;
          else
            tree_b[in_mon.node_index*HASH_WORDS_DEF + in_mon.word_index] = in_mon.hash_word;
        end else if (in_mon.cmd == CMD_RUN) begin
          predict_bitmap(in_mon.node_index);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (bitmap_q.size() == 0) begin
          report_mismatch("unexpected word", out_mon.map_word, '0);
        end else begin
          want = bitmap_q.pop_front();
          if (out_mon.map_word !== want.map_word)
            report_mismatch("map_word", out_mon.map_word, want.map_word);
          if (out_mon.map_index !== want.map_index)
            report_mismatch("map_index", out_mon.map_index, want.map_index);
          if (out_mon.subtree_equal !== want.subtree_equal)
            report_mismatch("subtree_equal", out_mon.subtree_equal, want.subtree_equal);
          if (out_mon.last !== want.last)
            report_mismatch("last", out_mon.last, want.last);
        end
      end
    end
  end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Loads two small hash trees with a planted pattern of differing nodes, then
// runs directed and random loads and difference runs across several level
// counts and idle patterns; the checker predicts and compares every bitmap word.
// ----------------------------------------------------------------------------
module tb_top;
  import mtd_pkg::*;

  localparam int NODE_CAP  = 2 * LEAVES_DEF - 1;
  localparam int PRE_NODES = 31;
  localparam int PRE_LEAF0 = 15;
  localparam int WD_LIMIT  = 40000;
  localparam logic [1:0] CMD_BAD = 2'd3;

  logic clk, rst, cfg_we;
  logic [LVW-1:0] cfg_wdata;
  int fail_count, words_pending, idle_cycles;
  int send_gap_pct, stall_pct;
  logic [63:0] shadow_a [NODE_CAP*HASH_WORDS_DEF];
  logic [63:0] shadow_b [NODE_CAP*HASH_WORDS_DEF];

  mtd_in_if  in_ch();
  mtd_out_if out_ch();

  merkle_tree_diff_map_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  mtd_diff_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the bitmap side at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Present one command word and hold it until accepted
  task automatic send_word(input logic [1:0] cmd, input logic [8:0] node,
                           input logic [1:0] widx, input logic [63:0] hw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.cmd = cmd;
    in_ch.node_index = node;
    in_ch.word_index = widx;
    in_ch.hash_word = hw;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (node < NODE_CAP && cmd == CMD_LOAD_A) shadow_a[node*HASH_WORDS_DEF+widx] = hw;
    if (node < NODE_CAP && cmd == CMD_LOAD_B) shadow_b[node*HASH_WORDS_DEF+widx] = hw;
  endtask

  // Drain all bitmap words, then write the level count
  task automatic set_levels(input logic [LVW-1:0] lv);
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wdata = lv;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random command: mostly loads that copy or break the other tree, else runs or, rarely, an invalid command
  task automatic random_word();
    int r, n, w;
    logic [63:0] v;
    r = $urandom_range(99);
    n = $urandom_range(PRE_NODES - 1);
    w = $urandom_range(3);
    if (r < 60) begin
      if (n >= NODE_CAP) v = {$urandom, $urandom};
      else if ($urandom_range(1)) v = (r < 30) ? shadow_b[n*4+w] : shadow_a[n*4+w];
      else v = {$urandom, $urandom};
      send_word((r < 30) ? CMD_LOAD_A : CMD_LOAD_B, n[8:0], w[1:0], v);
    end else if (r < 95) begin
      send_word(CMD_RUN, 9'($urandom_range(PRE_NODES)), w[1:0], {$urandom, $urandom});
    end else begin
      send_word(CMD_BAD, n[8:0], w[1:0], {$urandom, $urandom});
    end
  endtask

  initial begin
    logic differs [NODE_CAP];
    logic [63:0] v;
    logic [LVW-1:0] phase_levels [8];
    int dw;
    phase_levels = '{4'd5, 4'd0, 4'd4, 4'd1, 4'd5, 4'd3, 4'd2, 4'd5};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD_A;
    in_ch.node_index = '0;
    in_ch.word_index = '0;
    in_ch.hash_word = '0;
    send_gap_pct = 0;
    stall_pct = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Preload a five-level tree; differences climb from leaves toward the root
    for (int n = PRE_NODES - 1; n >= 0; n--) begin
      if (n >= PRE_LEAF0) differs[n] = ($urandom_range(99) < 30);
      else if (differs[2*n+1] || differs[2*n+2]) differs[n] = ($urandom_range(99) < 85);
      else differs[n] = ($urandom_range(99) < 5);
      dw = $urandom_range(3);
      for (int w = 0; w < HASH_WORDS_DEF; w++) begin
        v = {$urandom, $urandom};
        send_word(CMD_LOAD_A, 9'(n), 2'(w), v);
        send_word(CMD_LOAD_B, 9'(n), 2'(w), (differs[n] && w == dw) ? ~v : v);
      end
    end

    // Directed: extremes, every command, leaf roots, equal and outside roots
    set_levels(4'd5);
    send_word(CMD_RUN, 9'd0, 2'd0, '0);
    send_word(CMD_RUN, 9'd1, 2'd0, '1);
    send_word(CMD_RUN, 9'd30, 2'd3, '0);
    send_word(CMD_RUN, 9'd15, 2'd0, '0);
    send_word(CMD_RUN, 9'd31, 2'd0, '0);
    for (int w = 0; w < HASH_WORDS_DEF; w++)
      send_word(CMD_LOAD_B, 9'd30, 2'(w), shadow_a[30*HASH_WORDS_DEF+w]);
    send_word(CMD_RUN, 9'd30, 2'd0, '0);
    send_word(CMD_RUN, 9'd14, 2'd0, '0);
    send_word(CMD_LOAD_B, 9'd30, 2'd3, ~shadow_a[30*HASH_WORDS_DEF+3]);
    send_word(CMD_RUN, 9'd30, 2'd0, '0);
    send_word(CMD_LOAD_A, 9'd511, 2'd2, '1);
    send_word(CMD_LOAD_B, 9'd511, 2'd1, '1);
    send_word(CMD_BAD, 9'd0, 2'd0, '1);
    send_word(CMD_RUN, 9'd511, 2'd0, '0);

    // A lone leaf of the full-size tree, first with the level count saturated
    for (int w = 0; w < HASH_WORDS_DEF; w++) begin
      v = {$urandom, $urandom};
      send_word(CMD_LOAD_A, 9'd300, 2'(w), v);
      send_word(CMD_LOAD_B, 9'd300, 2'(w), v);
    end
    set_levels(4'd15);
    send_word(CMD_RUN, 9'd300, 2'd0, '0);
    send_word(CMD_LOAD_B, 9'd300, 2'd1, ~shadow_a[300*HASH_WORDS_DEF+1]);
    set_levels(4'd9);
    send_word(CMD_RUN, 9'd300, 2'd0, '0);
    send_word(CMD_RUN, 9'd511, 2'd0, '0);
    set_levels(4'd3);
    send_word(CMD_RUN, 9'd0, 2'd0, '0);
    send_word(CMD_RUN, 9'd6, 2'd0, '0);
    send_word(CMD_RUN, 9'd7, 2'd0, '0);
    send_word(CMD_RUN, 9'd100, 2'd0, '0);

    // Random phases over level counts and idle patterns
    for (int p = 0; p < 8; p++) begin
      set_levels(phase_levels[p]);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 78; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 78; end
        default: begin send_gap_pct = 13; stall_pct = 13; end
      endcase
      repeat (18) random_word();
    end
    in_ch.valid = 1'b0;

    // Drain and settle
    while (words_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: filelist.f
sv/mtd_pkg.sv
sv/mtd_in_if.sv
sv/mtd_out_if.sv
sv/mtd_ram.sv
sv/merkle_tree_diff_map_top.sv
sv/mtd_chk.sv
tb/mtd_diff_checker.sv
tb/tb_top.sv
